// ----- rtl/distinct_window_marker_detector_macros.svh -----
// Assertion macros used by the distinct window marker detector top level.
`ifndef DISTINCT_WINDOW_MARKER_DETECTOR_MACROS_SVH
`define DISTINCT_WINDOW_MARKER_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DWMD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DWMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dwmd_pkg.sv -----
// Package with payload types and fixed constants of the distinct window marker detector.
`default_nettype none

package dwmd_pkg;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned WS_W       = 5;
  localparam int unsigned POS_OUT_W  = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register map and reset values.
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE   = '0;
  localparam logic [WS_W-1:0]       WINDOW_SIZE_RESET = WS_W'(4);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } dwmd_in_t;

  typedef struct packed {
    logic                 marker_found;
    logic [POS_OUT_W-1:0] position;
    logic                 locked;
  } dwmd_out_t;

endpackage

`default_nettype wire

// ----- rtl/dwmd_out_buf.sv -----
// Two-entry result buffer (output register plus skid register) for the detector.
`default_nettype none

module dwmd_out_buf
  import dwmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire dwmd_out_t push_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output dwmd_out_t      out_data
);

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  dwmd_out_t main_r, main_nxt;
  dwmd_out_t skid_r, skid_nxt;
  logic      push, pop;

  // A new result is taken whenever the skid slot is free.
  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_v_r && out_ready;

  // Next-state of the two slots.
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Slot payloads.
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

`default_nettype wire

// ----- rtl/distinct_window_marker_detector.sv -----
// Top level of the distinct window marker detector: window taps, match flags and control.
// The block accepts one symbol per clock and returns one result per symbol, registered
// after the transfer; the result goes through a two-entry output buffer, so a symbol is
// taken on every cycle in which the buffer's skid slot is free. The window is kept as a
// shift line of MAX_WINDOW symbol taps, and each tap carries registered match flags
// against the taps older than it, so an arriving symbol needs only MAX_WINDOW-1 byte
// compares and an OR over the flags inside the window. A restart transfer or a write of
// window_size starts a new stream; there is no clearing pass. Once a marker is reported
// the window freezes and only the position advances, saturating at 2^POSITION_BITS-1.
`default_nettype none

module distinct_window_marker_detector
  import dwmd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW    = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dwmd_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dwmd_out_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  `include "distinct_window_marker_detector_macros.svh"

  localparam int unsigned WB_RAW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WB     = (WB_RAW > WS_W) ? WB_RAW : WS_W;

  // Configuration and stream state.
  logic [WS_W-1:0]          ws_r;
  logic [POSITION_BITS-1:0] cnt_r, cnt_nxt, cnt_base;
  logic                     found_r, found_base;

  // Window taps (tap 0 is the newest) and match flags: bit d of tap i is set
  // when tap i holds the same symbol as tap i+d.
  logic [SYM_W-1:0]      tap_r  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] dupv_r [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] dupv_new;

  logic [WB-1:0] eff_w;
  logic          take, cfg_wr, res_ready;
  logic          dup_any, win_full, marker, locked;
  dwmd_out_t     res;

  // APB register access; the port never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_WINDOW_SIZE);
  assign prdata = (paddr == REG_WINDOW_SIZE) ? CFG_DATA_W'(ws_r) : '0;

  // Window size in use: zero acts as one, large values clip to the tap count.
  always_comb begin
    if (ws_r == '0) begin
      eff_w = WB'(1);
    end else if (WB'(ws_r) > WB'(MAX_WINDOW)) begin
      eff_w = WB'(MAX_WINDOW);
    end else begin
      eff_w = WB'(ws_r);
    end
  end

  // A restart transfer sees a fresh stream.
  assign cnt_base   = in_data.restart ? '0 : cnt_r;
  assign found_base = in_data.restart ? 1'b0 : found_r;
  assign cnt_nxt    = (&cnt_base) ? cnt_base : cnt_base + 1'b1;
  assign win_full   = cnt_nxt >= POSITION_BITS'(eff_w);

  // Compare the arriving symbol against the stored taps.
  always_comb begin
    dupv_new[0] = 1'b0;
    for (int d = 1; d < MAX_WINDOW; d++) begin
      dupv_new[d] = (in_data.symbol == tap_r[d-1]);
    end
  end

  // Any matching pair among the newest eff_w symbols, arriving one included.
  always_comb begin
    dup_any = 1'b0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      for (int d = 1; d < MAX_WINDOW; d++) begin
        if ((i + d) < int'(eff_w)) begin
          if (i == 0) begin
            dup_any = dup_any | dupv_new[d];
          end else begin
            dup_any = dup_any | dupv_r[i-1][d];
          end
        end
      end
    end
  end

  assign marker = !found_base && win_full && !dup_any;
  assign locked = found_base || marker;

  assign res.marker_found = marker;
  assign res.position     = POS_OUT_W'(cnt_nxt);
  assign res.locked       = locked;

  assign in_ready = res_ready;
  assign take     = in_valid && in_ready;

  // Stream control and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= WINDOW_SIZE_RESET;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cfg_wr) begin
      ws_r    <= pwdata[WS_W-1:0];
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      found_r <= locked;
    end
  end

  // Window shift line; frozen while the stream is locked.
  always_ff @(posedge clk) begin
    if (take && !found_base) begin
      tap_r[0]  <= in_data.symbol;
      dupv_r[0] <= dupv_new;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        tap_r[i]  <= tap_r[i-1];
        dupv_r[i] <= dupv_r[i-1];
      end
    end
  end

  // Result buffer toward the output channel.
  dwmd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (res_ready),
    .push_data  (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Checks on the detector's own logic.
  `DWMD_ASSERT_IMPL(a_marker_locks, out_valid && out_data.marker_found, out_data.locked, "marker result without lock")
  `DWMD_ASSERT_IMPL(a_stall_has_result, !in_ready, out_valid, "input stalled with no result pending")
  `DWMD_ASSERT_NEXT(a_lock_holds, take && !in_data.restart && found_r && !cfg_wr, found_r, "lock dropped without restart")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the distinct window marker detector.
`timescale 1ns / 100ps

module testbench;
  import dwmd_pkg::*;

  localparam int unsigned MAX_W       = 16;
  localparam int unsigned HOLD_CYCLES = 240;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam longint unsigned POS_CEILING = 64'h0000_0000_FFFF_FFFF;

  // Predicts each marker result and checks the block's results against it.
  class marker_scoreboard;
    logic [7:0]      recent_syms[MAX_W];
    int unsigned     head;
    int unsigned     sym_counts[256];
    int unsigned     dup_values;
    longint unsigned stream_len;
    bit              locked;
    logic [WS_W-1:0] window_reg;
    dwmd_out_t       expected_q[$];
    int unsigned     errors;

    function new();
      window_reg = WINDOW_SIZE_RESET;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (recent_syms[i]) recent_syms[i] = 8'h00;
      foreach (sym_counts[i]) sym_counts[i] = 0;
      head = 0;
      dup_values = 0;
      stream_len = 0;
      locked = 1'b0;
    endfunction

    // A new window size also starts a new stream.
    function void write_window(logic [WS_W-1:0] value);
      window_reg = value;
      clear_stream();
    endfunction

    function int unsigned active_window();
      if (window_reg == 0) return 1;
      if (window_reg > MAX_W) return MAX_W;
      return window_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Updates the window and counts for one accepted symbol and queues its result.
    function void note_input(dwmd_in_t item);
      int unsigned w;
      int unsigned slot;
      logic [7:0]  old_sym;
      dwmd_out_t   res;
      w = active_window();
      res.marker_found = 1'b0;
      if (item.restart) clear_stream();
      if (!locked) begin
        if (stream_len >= w) begin
          slot = (head + MAX_W - w) % MAX_W;
          old_sym = recent_syms[slot];
          if (sym_counts[old_sym] == 2) dup_values--;
          if (sym_counts[old_sym] > 0) sym_counts[old_sym]--;
        end
        if (sym_counts[item.symbol] == 1) dup_values++;
        if (sym_counts[item.symbol] < 255) sym_counts[item.symbol]++;
        recent_syms[head] = item.symbol;
        head = (head + 1) % MAX_W;
      end
      if (stream_len < POS_CEILING) stream_len++;
      if (!locked && stream_len >= w && dup_values == 0) begin
        res.marker_found = 1'b1;
        locked = 1'b1;
      end
      res.position = stream_len[POS_OUT_W-1:0];
      res.locked = locked;
      expected_q.push_back(res);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compares one result transfer with the oldest expected result.
    task check_result(dwmd_out_t got);
      dwmd_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing outstanding, position %0d", got.position));
        return;
      end
      want = expected_q.pop_front();
      if (got.marker_found !== want.marker_found)
        report($sformatf("marker_found %b, want %b at position %0d",
                         got.marker_found, want.marker_found, want.position));
      if (got.position !== want.position)
        report($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.locked !== want.locked)
        report($sformatf("locked %b, want %b at position %0d",
                         got.locked, want.locked, want.position));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  dwmd_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  dwmd_out_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  marker_scoreboard sb;
  bit               steady_mode;
  bit               hold_request;
  int unsigned      stall_left;
  int unsigned      cycle_count;

  // Stream generator state: a run of distinct symbols with occasional repeats.
  logic [7:0]  run_base;
  int unsigned run_span;
  int unsigned run_step;
  int unsigned run_glitch;

  distinct_window_marker_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths: mostly short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dwmd_in_t next_stream_item(int unsigned w);
    dwmd_in_t    item;
    int unsigned roll;
    item.restart = 1'b0;
    if ($urandom_range(0, 99) < 4) begin
      item.restart = 1'b1;
      run_base = 8'($urandom_range(0, 255));
      run_span = w + $urandom_range(0, 2);
      run_step = 0;
      roll = $urandom_range(0, 2);
      run_glitch = (roll == 0) ? 0 : ((roll == 1) ? 4 : 20);
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      item.symbol = 8'($urandom_range(0, 255));
    end else if (roll < 6 + run_glitch) begin
      item.symbol = run_base + 8'($urandom_range(0, run_span - 1));
    end else begin
      item.symbol = run_base + 8'(run_step % run_span);
      run_step++;
    end
    return item;
  endfunction

  function automatic int unsigned effective_window(int unsigned value);
    if (value == 0) return 1;
    if (value > MAX_W) return MAX_W;
    return value;
  endfunction

  // Offers one symbol and returns at the edge where it is transferred.
  task automatic send_item(input dwmd_in_t item);
    int unsigned gap;
    gap = 0;
    if (!steady_mode && $urandom_range(0, 99) < 35) gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_sym(input logic [7:0] sym, input logic restart);
    dwmd_in_t item;
    item.symbol  = sym;
    item.restart = restart;
    send_item(item);
  endtask

  // Stops offering and waits until every expected result has come back.
  // The first edge lets the monitor record the last transfer before counting.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB access: setup phase, access phase, then idle.
  task automatic cfg_access(input bit is_write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_window_reg(input logic [WS_W-1:0] want);
    logic [CFG_DATA_W-1:0] rdata;
    cfg_access(1'b0, REG_WINDOW_SIZE, '0, rdata);
    if (rdata[WS_W-1:0] !== want)
      sb.report($sformatf("window_size reads %0d, want %0d", rdata[WS_W-1:0], want));
  endtask

  task automatic set_window(input int unsigned value);
    logic [CFG_DATA_W-1:0] unused;
    cfg_access(1'b1, REG_WINDOW_SIZE, CFG_DATA_W'(value), unused);
    sb.write_window(WS_W'(value));
    check_window_reg(WS_W'(value));
  endtask

  // Record every symbol transfer and check every result transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side: random stalls, plus one long hold-off counted here.
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!steady_mode && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Main stimulus sequence.
  initial begin
    logic [8:0]  short_win_items[15];
    int unsigned phase_windows[11];
    int unsigned w;

    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady_mode = 1'b0;
    hold_request = 1'b0;
    cycle_count = 0;
    run_base = 8'h00;
    run_span = 4;
    run_step = 0;
    run_glitch = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_window_reg(WINDOW_SIZE_RESET);

    // Directed part at the reset window size: first marker, locked symbols,
    // restart after a repeated run, and a stream cut short by a restart.
    short_win_items = '{
      {8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0}, {8'h02, 1'b0},
      {8'h55, 1'b0}, {8'hAA, 1'b0},
      {8'hFF, 1'b1}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'h80, 1'b0}, {8'h7F, 1'b0},
      {8'h10, 1'b1}, {8'h20, 1'b0}, {8'h30, 1'b1}
    };
    foreach (short_win_items[i]) send_item(dwmd_in_t'(short_win_items[i]));
    drain_results();

    // Window of one symbol, then the zero setting that acts as one.
    set_window(1);
    send_sym(8'h12, 1'b0);
    send_sym(8'h12, 1'b1);
    send_sym(8'hAB, 1'b0);
    drain_results();
    set_window(0);
    send_sym(8'h00, 1'b0);
    send_sym(8'hFE, 1'b0);
    drain_results();

    // Random phases over several window sizes, the extremes among them.
    phase_windows = '{16, 31, 2, 17, 0, 1, 8, 5, 3, 12, 0};
    phase_windows[10] = $urandom_range(0, 31);
    foreach (phase_windows[p]) begin
      set_window(phase_windows[p]);
      w = effective_window(phase_windows[p]);
      run_base = 8'($urandom_range(0, 255));
      run_span = w + $urandom_range(0, 2);
      run_step = 0;
      run_glitch = 4;
      steady_mode = (p == 1 || p == 3 || p == 7);
      // Hold the result side off while symbols keep coming.
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(next_stream_item(w));
      drain_results();
      steady_mode = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
